>>> design/x86br_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// x86br_pkg
// Types and constants shared by the 16-bit x86 branch unit.
// ============================================================================
package x86br_pkg;

    typedef enum logic [3:0] {
        FN_JMP_REL8  = 4'd0,
        FN_JMP_REL16 = 4'd1,
        FN_JMP_FAR   = 4'd2,
        FN_JCC       = 4'd3,
        FN_LOOP      = 4'd4,
        FN_LOOPZ     = 4'd5,
        FN_JCXZ      = 4'd6,
        FN_CALL_NEAR = 4'd7,
        FN_CALL_FAR  = 4'd8,
        FN_RET       = 4'd9,
        FN_RETF      = 4'd10,
        FN_IRET      = 4'd11,
        FN_INT3      = 4'd12,
        FN_INTO      = 4'd13,
        FN_INTN      = 4'd14,
        FN_HLT       = 4'd15
    } func_t;

    // Jcc condition pairs, selected by bits 3:1 of the condition nibble.
    typedef enum logic [2:0] {
        CC_O  = 3'd0,
        CC_C  = 3'd1,
        CC_Z  = 3'd2,
        CC_BE = 3'd3,
        CC_S  = 3'd4,
        CC_P  = 3'd5,
        CC_L  = 3'd6,
        CC_LE = 3'd7
    } cc_t;

    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 2;
    localparam int FLAG_ZF = 6;
    localparam int FLAG_SF = 7;
    localparam int FLAG_OF = 11;

    localparam logic [7:0] VEC_INT3 = 8'd3;
    localparam logic [7:0] VEC_INTO = 8'd4;

    localparam logic [15:0] SP_NEAR_PUSH = 16'hFFFE;
    localparam logic [15:0] SP_FAR_PUSH  = 16'hFFFC;
    localparam logic [15:0] SP_NEAR_POP  = 16'd2;
    localparam logic [15:0] SP_FAR_POP   = 16'd4;
    localparam logic [15:0] SP_IRET_POP  = 16'd6;

    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  cond;
        logic [15:0] imm;
        logic [15:0] imm_seg;
        logic [15:0] ip;
        logic [15:0] cs;
        logic [15:0] sp;
        logic [15:0] cx;
        logic [15:0] flags;
        logic [15:0] pop_ip;
        logic [15:0] pop_cs;
        logic [15:0] pop_flags;
    } item_t;

    typedef struct packed {
        logic [15:0] new_ip;
        logic [15:0] new_cs;
        logic [15:0] new_sp;
        logic [15:0] new_cx;
        logic [15:0] new_flags;
        logic [1:0]  push_count;
        logic [15:0] push_first;
        logic [15:0] push_second;
        logic        irq_valid;
        logic [7:0]  irq_number;
        logic        halted;
    } result_t;

endpackage

>>> design/x86_16_branch_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// x86_16_branch_unit
// Resolves one 16-bit x86 control-transfer instruction per clock.
// ============================================================================
// Usage:
// An instruction is transferred in at a rising edge where start is high and
// busy is low. busy never rises, so a new instruction may be given in every
// cycle. The fields are captured into an input register, resolved by one
// pass of logic (one IP adder, one SP adder and condition selection) and
// captured into the result register.
// The result appears on the result ports after the input register and the
// result register, for exactly one cycle, marked by done. Results leave in
// the order in which instructions came in, one per instruction, one per
// cycle at most. Throughput is one instruction per cycle, since busy is
// tied low and the resolve logic takes a single pass.
// The receiver has no way to stall the unit and must take each result in
// the cycle that done is high.
// Reset clears the valid flags of both stages; instructions in flight at
// reset are dropped, and no result is invented across it.
// ============================================================================
module x86_16_branch_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  func,
    input  logic [3:0]  cond,
    input  logic [15:0] imm,
    input  logic [15:0] imm_seg,
    input  logic [15:0] ip,
    input  logic [15:0] cs,
    input  logic [15:0] sp,
    input  logic [15:0] cx,
    input  logic [15:0] flags,
    input  logic [15:0] pop_ip,
    input  logic [15:0] pop_cs,
    input  logic [15:0] pop_flags,
    output logic        done,
    output logic [15:0] new_ip,
    output logic [15:0] new_cs,
    output logic [15:0] new_sp,
    output logic [15:0] new_cx,
    output logic [15:0] new_flags,
    output logic [1:0]  push_count,
    output logic [15:0] push_first,
    output logic [15:0] push_second,
    output logic        irq_valid,
    output logic [7:0]  irq_number,
    output logic        halted
);

    x86br_pkg::item_t   item_reg;
    x86br_pkg::item_t   item_next;
    logic               item_valid_reg;
    x86br_pkg::result_t res_next;
    x86br_pkg::result_t res_reg;
    logic               res_valid_reg;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign item_next = '{func:      func,
                         cond:      cond,
                         imm:       imm,
                         imm_seg:   imm_seg,
                         ip:        ip,
                         cs:        cs,
                         sp:        sp,
                         cx:        cx,
                         flags:     flags,
                         pop_ip:    pop_ip,
                         pop_cs:    pop_cs,
                         pop_flags: pop_flags};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
            res_valid_reg  <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        if (item_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    x86br_resolve u_resolve
    (
        .item (item_reg),
        .res  (res_next)
    );

    assign done        = res_valid_reg;
    assign new_ip      = res_reg.new_ip;
    assign new_cs      = res_reg.new_cs;
    assign new_sp      = res_reg.new_sp;
    assign new_cx      = res_reg.new_cx;
    assign new_flags   = res_reg.new_flags;
    assign push_count  = res_reg.push_count;
    assign push_first  = res_reg.push_first;
    assign push_second = res_reg.push_second;
    assign irq_valid   = res_reg.irq_valid;
    assign irq_number  = res_reg.irq_number;
    assign halted      = res_reg.halted;

`ifndef SYNTHESIS
    // Every transfer in yields exactly one result, after the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("result missing two cycles after a transfer in");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 2))
        else $error("result without a matching transfer in");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && halted) |-> (!irq_valid && (push_count == 2'd0)))
        else $error("halt result also pushes or raises an interrupt");

    a_irq_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !irq_valid) |-> (irq_number == 8'd0))
        else $error("interrupt number set without a pending interrupt");

    a_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (push_count == 2'd0)) |-> ((push_first == 16'd0) && (push_second == 16'd0)))
        else $error("push words set without a push");
`endif

endmodule

>>> design/x86br_resolve.sv
`timescale 1ns / 1ps
// ============================================================================
// x86br_resolve
// Combinational resolution of one control-transfer instruction.
// ============================================================================
module x86br_resolve
(
    input  x86br_pkg::item_t   item,
    output x86br_pkg::result_t res
);

    x86br_pkg::func_t  fn;
    x86br_pkg::cc_t    cc;
    logic              cc_base;
    logic              cc_taken;
    logic              cf;
    logic              pf;
    logic              zf;
    logic              sf;
    logic              of;
    logic [15:0]       cx_dec;
    logic              use_short;
    logic [15:0]       disp;
    logic [15:0]       rel_target;
    logic [15:0]       sp_delta;
    logic [15:0]       sp_sum;

    assign fn = x86br_pkg::func_t'(item.func);
    assign cc = x86br_pkg::cc_t'(item.cond[3:1]);

    assign cf = item.flags[x86br_pkg::FLAG_CF];
    assign pf = item.flags[x86br_pkg::FLAG_PF];
    assign zf = item.flags[x86br_pkg::FLAG_ZF];
    assign sf = item.flags[x86br_pkg::FLAG_SF];
    assign of = item.flags[x86br_pkg::FLAG_OF];

    always_comb
    begin
        unique case (cc)
            x86br_pkg::CC_O:  cc_base = of;
            x86br_pkg::CC_C:  cc_base = cf;
            x86br_pkg::CC_Z:  cc_base = zf;
            x86br_pkg::CC_BE: cc_base = cf | zf;
            x86br_pkg::CC_S:  cc_base = sf;
            x86br_pkg::CC_P:  cc_base = pf;
            x86br_pkg::CC_L:  cc_base = sf ^ of;
            x86br_pkg::CC_LE: cc_base = zf | (sf ^ of);
            default:          cc_base = 1'b0;
        endcase
    end

    assign cc_taken = cc_base ^ item.cond[0];
    assign cx_dec   = item.cx - 16'd1;

    // One adder serves both the short and the near relative forms.
    assign use_short  = (fn != x86br_pkg::FN_JMP_REL16) && (fn != x86br_pkg::FN_CALL_NEAR);
    assign disp       = use_short ? {{8{item.imm[7]}}, item.imm[7:0]} : item.imm;
    assign rel_target = item.ip + disp;

    always_comb
    begin
        case (fn)
            x86br_pkg::FN_CALL_NEAR: sp_delta = x86br_pkg::SP_NEAR_PUSH;
            x86br_pkg::FN_CALL_FAR:  sp_delta = x86br_pkg::SP_FAR_PUSH;
            x86br_pkg::FN_RET:       sp_delta = x86br_pkg::SP_NEAR_POP + item.imm;
            x86br_pkg::FN_RETF:      sp_delta = x86br_pkg::SP_FAR_POP + item.imm;
            x86br_pkg::FN_IRET:      sp_delta = x86br_pkg::SP_IRET_POP;
            default:                 sp_delta = 16'd0;
        endcase
    end

    assign sp_sum = item.sp + sp_delta;

    always_comb
    begin
        res.new_ip      = item.ip;
        res.new_cs      = item.cs;
        res.new_sp      = sp_sum;
        res.new_cx      = item.cx;
        res.new_flags   = item.flags;
        res.push_count  = 2'd0;
        res.push_first  = 16'd0;
        res.push_second = 16'd0;
        res.irq_valid   = 1'b0;
        res.irq_number  = 8'd0;
        res.halted      = 1'b0;
        unique case (fn)
            x86br_pkg::FN_JMP_REL8,
            x86br_pkg::FN_JMP_REL16:
            begin
                res.new_ip = rel_target;
            end
            x86br_pkg::FN_JMP_FAR:
            begin
                res.new_ip = item.imm;
                res.new_cs = item.imm_seg;
            end
            x86br_pkg::FN_JCC:
            begin
                if (cc_taken)
                begin
                    res.new_ip = rel_target;
                end
            end
            x86br_pkg::FN_LOOP:
            begin
                res.new_cx = cx_dec;
                if (cx_dec != 16'd0)
                begin
                    res.new_ip = rel_target;
                end
            end
            x86br_pkg::FN_LOOPZ:
            begin
                res.new_cx = cx_dec;
                if ((cx_dec != 16'd0) && (zf == item.cond[0]))
                begin
                    res.new_ip = rel_target;
                end
            end
            x86br_pkg::FN_JCXZ:
            begin
                if (item.cx == 16'd0)
                begin
                    res.new_ip = rel_target;
                end
            end
            x86br_pkg::FN_CALL_NEAR:
            begin
                res.push_count = 2'd1;
                res.push_first = item.ip;
                res.new_ip     = rel_target;
            end
            x86br_pkg::FN_CALL_FAR:
            begin
                res.push_count  = 2'd2;
                res.push_first  = item.cs;
                res.push_second = item.ip;
                res.new_ip      = item.imm;
                res.new_cs      = item.imm_seg;
            end
            x86br_pkg::FN_RET:
            begin
                res.new_ip = item.pop_ip;
            end
            x86br_pkg::FN_RETF:
            begin
                res.new_ip = item.pop_ip;
                res.new_cs = item.pop_cs;
            end
            x86br_pkg::FN_IRET:
            begin
                res.new_ip    = item.pop_ip;
                res.new_cs    = item.pop_cs;
                res.new_flags = item.pop_flags;
            end
            x86br_pkg::FN_INT3:
            begin
                res.irq_valid  = 1'b1;
                res.irq_number = x86br_pkg::VEC_INT3;
            end
            x86br_pkg::FN_INTO:
            begin
                if (of)
                begin
                    res.irq_valid  = 1'b1;
                    res.irq_number = x86br_pkg::VEC_INTO;
                end
            end
            x86br_pkg::FN_INTN:
            begin
                res.irq_valid  = 1'b1;
                res.irq_number = item.imm[7:0];
            end
            x86br_pkg::FN_HLT:
            begin
                res.halted = 1'b1;
            end
            default:
            begin
                res.halted = 1'b0;
            end
        endcase
    end

endmodule

>>> dv/x86_16_branch_unit_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// x86_16_branch_unit_checker
// Watches the command and result ports of the branch unit and checks each
// result against an independent prediction.
// ============================================================================
// Every instruction transfer is resolved into its expected result when it is
// accepted. Each result the unit strobes out with done is compared, field by
// field, against the oldest expected result still waiting. The number of
// mismatches and the number of results still owed go back to the testbench.
// ============================================================================
module x86_16_branch_unit_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [3:0]  func,
    input  logic [3:0]  cond,
    input  logic [15:0] imm,
    input  logic [15:0] imm_seg,
    input  logic [15:0] ip,
    input  logic [15:0] cs,
    input  logic [15:0] sp,
    input  logic [15:0] cx,
    input  logic [15:0] flags,
    input  logic [15:0] pop_ip,
    input  logic [15:0] pop_cs,
    input  logic [15:0] pop_flags,
    input  logic        done,
    input  logic [15:0] new_ip,
    input  logic [15:0] new_cs,
    input  logic [15:0] new_sp,
    input  logic [15:0] new_cx,
    input  logic [15:0] new_flags,
    input  logic [1:0]  push_count,
    input  logic [15:0] push_first,
    input  logic [15:0] push_second,
    input  logic        irq_valid,
    input  logic [7:0]  irq_number,
    input  logic        halted,
    output int          errors,
    output int          outstanding
);

    x86br_pkg::result_t expected_results[$];
    int                 result_index;

    function automatic x86br_pkg::result_t resolve_branch(input x86br_pkg::item_t op);
        x86br_pkg::result_t r;
        logic [15:0]        short_target;
        logic [15:0]        cx_next;
        logic               cc_true;
        logic               f_cf;
        logic               f_pf;
        logic               f_zf;
        logic               f_sf;
        logic               f_of;
        begin
            r.new_ip      = op.ip;
            r.new_cs      = op.cs;
            r.new_sp      = op.sp;
            r.new_cx      = op.cx;
            r.new_flags   = op.flags;
            r.push_count  = 2'd0;
            r.push_first  = 16'h0000;
            r.push_second = 16'h0000;
            r.irq_valid   = 1'b0;
            r.irq_number  = 8'h00;
            r.halted      = 1'b0;

            f_cf = op.flags[x86br_pkg::FLAG_CF];
            f_pf = op.flags[x86br_pkg::FLAG_PF];
            f_zf = op.flags[x86br_pkg::FLAG_ZF];
            f_sf = op.flags[x86br_pkg::FLAG_SF];
            f_of = op.flags[x86br_pkg::FLAG_OF];

            // Short forms only look at the low byte of the displacement.
            short_target = op.ip + {{8{op.imm[7]}}, op.imm[7:0]};
            cx_next      = op.cx - 16'd1;

            case (x86br_pkg::cc_t'(op.cond[3:1]))
                x86br_pkg::CC_O:  cc_true = f_of;
                x86br_pkg::CC_C:  cc_true = f_cf;
                x86br_pkg::CC_Z:  cc_true = f_zf;
                x86br_pkg::CC_BE: cc_true = f_cf | f_zf;
                x86br_pkg::CC_S:  cc_true = f_sf;
                x86br_pkg::CC_P:  cc_true = f_pf;
                x86br_pkg::CC_L:  cc_true = f_sf ^ f_of;
                default:          cc_true = f_zf | (f_sf ^ f_of);
            endcase
            cc_true = cc_true ^ op.cond[0];

            case (x86br_pkg::func_t'(op.func))
                x86br_pkg::FN_JMP_REL8:  r.new_ip = short_target;
                x86br_pkg::FN_JMP_REL16: r.new_ip = op.ip + op.imm;
                x86br_pkg::FN_JMP_FAR:
                begin
                    r.new_ip = op.imm;
                    r.new_cs = op.imm_seg;
                end
                x86br_pkg::FN_JCC:
                begin
                    if (cc_true)
                        r.new_ip = short_target;
                end
                x86br_pkg::FN_LOOP:
                begin
                    r.new_cx = cx_next;
                    if (cx_next != 16'h0000)
                        r.new_ip = short_target;
                end
                x86br_pkg::FN_LOOPZ:
                begin
                    r.new_cx = cx_next;
                    if (cx_next != 16'h0000 && f_zf == op.cond[0])
                        r.new_ip = short_target;
                end
                x86br_pkg::FN_JCXZ:
                begin
                    if (op.cx == 16'h0000)
                        r.new_ip = short_target;
                end
                x86br_pkg::FN_CALL_NEAR:
                begin
                    r.push_count = 2'd1;
                    r.push_first = op.ip;
                    r.new_sp     = op.sp - 16'd2;
                    r.new_ip     = op.ip + op.imm;
                end
                x86br_pkg::FN_CALL_FAR:
                begin
                    r.push_count  = 2'd2;
                    r.push_first  = op.cs;
                    r.push_second = op.ip;
                    r.new_sp      = op.sp - 16'd4;
                    r.new_ip      = op.imm;
                    r.new_cs      = op.imm_seg;
                end
                x86br_pkg::FN_RET:
                begin
                    r.new_ip = op.pop_ip;
                    r.new_sp = op.sp + 16'd2 + op.imm;
                end
                x86br_pkg::FN_RETF:
                begin
                    r.new_ip = op.pop_ip;
                    r.new_cs = op.pop_cs;
                    r.new_sp = op.sp + 16'd4 + op.imm;
                end
                x86br_pkg::FN_IRET:
                begin
                    r.new_ip    = op.pop_ip;
                    r.new_cs    = op.pop_cs;
                    r.new_flags = op.pop_flags;
                    r.new_sp    = op.sp + 16'd6;
                end
                x86br_pkg::FN_INT3:
                begin
                    r.irq_valid  = 1'b1;
                    r.irq_number = x86br_pkg::VEC_INT3;
                end
                x86br_pkg::FN_INTO:
                begin
                    if (f_of)
                    begin
                        r.irq_valid  = 1'b1;
                        r.irq_number = x86br_pkg::VEC_INTO;
                    end
                end
                x86br_pkg::FN_INTN:
                begin
                    r.irq_valid  = 1'b1;
                    r.irq_number = op.imm[7:0];
                end
                default:      r.halted = 1'b1;
            endcase
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        begin
            $display("ERROR at %0t: result %0d %s: expected %h, got %h",
                     $realtime, result_index, what, want, got);
            errors++;
        end
    endtask

    initial
    begin
        errors       = 0;
        result_index = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        x86br_pkg::result_t want;
        x86br_pkg::item_t   accepted;
        if (!rst_n)
        begin
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("arrived with no transfer pending", 16'h0000,
                                    new_ip);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (new_ip !== want.new_ip)
                        report_mismatch("new_ip", want.new_ip, new_ip);
                    if (new_cs !== want.new_cs)
                        report_mismatch("new_cs", want.new_cs, new_cs);
                    if (new_sp !== want.new_sp)
                        report_mismatch("new_sp", want.new_sp, new_sp);
                    if (new_cx !== want.new_cx)
                        report_mismatch("new_cx", want.new_cx, new_cx);
                    if (new_flags !== want.new_flags)
                        report_mismatch("new_flags", want.new_flags, new_flags);
                    if (push_count !== want.push_count)
                        report_mismatch("push_count", 16'(want.push_count),
                                        16'(push_count));
                    if (push_first !== want.push_first)
                        report_mismatch("push_first", want.push_first, push_first);
                    if (push_second !== want.push_second)
                        report_mismatch("push_second", want.push_second, push_second);
                    if (irq_valid !== want.irq_valid)
                        report_mismatch("irq_valid", 16'(want.irq_valid),
                                        16'(irq_valid));
                    if (irq_number !== want.irq_number)
                        report_mismatch("irq_number", 16'(want.irq_number),
                                        16'(irq_number));
                    if (halted !== want.halted)
                        report_mismatch("halted", 16'(want.halted), 16'(halted));
                end
                result_index++;
            end
            if (start && !busy)
            begin
                accepted = {func, cond, imm, imm_seg, ip, cs, sp, cx, flags,
                            pop_ip, pop_cs, pop_flags};
                expected_results.push_back(resolve_branch(accepted));
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> dv/x86_16_branch_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// x86_16_branch_unit_tb
// Testbench for the 16-bit x86 branch unit.
// ============================================================================
// A directed pass walks every operation with extreme register values and the
// corner cases of each: displacement wrap, the upper byte of short
// displacements, condition inversion, count wrap in LOOP, stack pointer
// wrap, IRET flag restore, interrupts with and without overflow, and halt.
// A long random pass follows with bursts of idle cycles and one full drain.
// The checker instantiated beside the unit predicts and compares results.
// ============================================================================
module x86_16_branch_unit_tb;

    localparam int RANDOM_ITEMS = 1850;
    localparam int QUIET_TAIL   = 250;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [3:0] SEL_LOOPNZ = 4'h0;
    localparam logic [3:0] SEL_LOOPZ  = 4'h1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [3:0]  func = '0;
    logic [3:0]  cond = '0;
    logic [15:0] imm = '0;
    logic [15:0] imm_seg = '0;
    logic [15:0] ip = '0;
    logic [15:0] cs = '0;
    logic [15:0] sp = '0;
    logic [15:0] cx = '0;
    logic [15:0] flags = '0;
    logic [15:0] pop_ip = '0;
    logic [15:0] pop_cs = '0;
    logic [15:0] pop_flags = '0;
    logic        done;
    logic [15:0] new_ip;
    logic [15:0] new_cs;
    logic [15:0] new_sp;
    logic [15:0] new_cx;
    logic [15:0] new_flags;
    logic [1:0]  push_count;
    logic [15:0] push_first;
    logic [15:0] push_second;
    logic        irq_valid;
    logic [7:0]  irq_number;
    logic        halted;
    int          errors;
    int          outstanding;
    int          cycle_count = 0;

    x86_16_branch_unit dut (.*);

    x86_16_branch_unit_checker checker_inst (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("x86_16_branch_unit test failed");
            $finish;
        end
    end

    function automatic x86br_pkg::item_t random_instruction();
        x86br_pkg::item_t it;
        begin
            it.func      = 4'($urandom_range(0, 15));
            it.cond      = 4'($urandom_range(0, 15));
            it.imm       = 16'($urandom);
            it.imm_seg   = 16'($urandom);
            it.ip        = 16'($urandom);
            it.cs        = 16'($urandom);
            it.sp        = 16'($urandom);
            // Small counts hit the loop exit and the count wrap.
            it.cx        = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
                                                       : 16'($urandom);
            it.flags     = 16'($urandom);
            it.pop_ip    = 16'($urandom);
            it.pop_cs    = 16'($urandom);
            it.pop_flags = 16'($urandom);
            return it;
        end
    endfunction

    // Holds one instruction on the ports until it is transferred.
    task automatic issue_instruction(input x86br_pkg::item_t it);
        begin
            start     <= 1'b1;
            func      <= it.func;
            cond      <= it.cond;
            imm       <= it.imm;
            imm_seg   <= it.imm_seg;
            ip        <= it.ip;
            cs        <= it.cs;
            sp        <= it.sp;
            cx        <= it.cx;
            flags     <= it.flags;
            pop_ip    <= it.pop_ip;
            pop_cs    <= it.pop_cs;
            pop_flags <= it.pop_flags;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    task automatic idle_burst();
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13))
                @(posedge clk);
        end
    endtask

    task automatic drain_results();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        x86br_pkg::item_t it;
        int               idle_odds;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        it = random_instruction();
        it.func = x86br_pkg::FN_JMP_REL8;  it.imm = 16'hFF80; it.ip = 16'h0010;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_JMP_REL8;  it.imm = 16'h007F; it.ip = 16'hFFF0;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_JMP_REL16; it.imm = 16'hFFFF; it.ip = 16'hFFFF;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_JMP_FAR;   it.imm = 16'hFFFF; it.imm_seg = 16'hFFFF;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_JCC; it.cond = {x86br_pkg::CC_O, 1'b0};
        it.flags = 16'h0000;
        it.flags[x86br_pkg::FLAG_OF] = 1'b1;
        issue_instruction(it);
        it.cond = {x86br_pkg::CC_O, 1'b1};
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_JCC; it.cond = {x86br_pkg::CC_LE, 1'b0};
        it.flags = 16'hFFFF;
        it.imm = 16'h1280;
        issue_instruction(it);
        it.cond = {x86br_pkg::CC_LE, 1'b1}; it.flags = 16'h0000;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_LOOP; it.cx = 16'h0001;
        issue_instruction(it);
        it.cx = 16'h0000;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_LOOPZ; it.cond = SEL_LOOPZ; it.cx = 16'h0005;
        it.flags[x86br_pkg::FLAG_ZF] = 1'b1;
        issue_instruction(it);
        it.cond = SEL_LOOPNZ;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_JCXZ; it.cx = 16'h0000;
        issue_instruction(it);
        it.cx = 16'hFFFF;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_CALL_NEAR; it.sp = 16'h0000; it.imm = 16'hFFFF;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_CALL_FAR; it.sp = 16'h0002;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_RET; it.sp = 16'hFFFE; it.imm = 16'hFFFF;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_RETF; it.imm = 16'h0000; it.pop_cs = 16'hFFFF;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_IRET; it.sp = 16'hFFFC; it.pop_flags = 16'hFFFF;
        it.flags = 16'h0000;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_INT3;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_INTO; it.flags[x86br_pkg::FLAG_OF] = 1'b1;
        issue_instruction(it);
        it.flags[x86br_pkg::FLAG_OF] = 1'b0;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_INTN; it.imm = 16'hFFFF;
        issue_instruction(it);
        it = random_instruction();
        it.func = x86br_pkg::FN_HLT;
        issue_instruction(it);

        idle_odds = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Each stretch of the run gets its own idling density, zero at times.
            if (n % 100 == 0)
                idle_odds = $urandom_range(0, 3);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            else if (n < RANDOM_ITEMS - QUIET_TAIL && idle_odds != 0 &&
                     $urandom_range(1, 8) <= idle_odds)
                idle_burst();
            issue_instruction(random_instruction());
        end

        drain_results();
        repeat (8)
            @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("x86_16_branch_unit test passed");
        else
            $display("x86_16_branch_unit test failed");
        $finish;
    end

endmodule

>>> filelist.f
design/x86br_pkg.sv
design/x86br_resolve.sv
design/x86_16_branch_unit.sv
dv/x86_16_branch_unit_checker.sv
dv/x86_16_branch_unit_tb.sv
